// ===== sv/tlc_pkg.sv =====
// tlc_pkg: shared types, constants and code tables of the traffic light sequencer
// no dependencies; imported by every module of the block

package tlc_pkg;

  localparam int DUR_W           = 16;
  localparam int REG_COUNT       = 4;
  localparam int DIGIT_COUNT_DEF = 4;
  localparam int DP_DIGIT        = 2;

  localparam logic [7:0] LAMP_DARK   = 8'hFF;
  localparam logic [7:0] LAMP_RED    = 8'hFC;
  localparam logic [7:0] LAMP_GREEN  = 8'hF3;
  localparam logic [7:0] LAMP_YELLOW = 8'hCF;
  localparam logic [7:0] DP_BIT      = 8'h80;

  localparam logic [DUR_W-1:0] STARTUP_RST = 16'd100;
  localparam logic [DUR_W-1:0] RED_RST     = 16'd3000;
  localparam logic [DUR_W-1:0] GREEN_RST   = 16'd1000;
  localparam logic [DUR_W-1:0] YELLOW_RST  = 16'd300;

  // x / 10 for any 16-bit x: (x * 52429) >> 19
  localparam logic [15:0] DIV10_MUL = 16'd52429;
  localparam int          DIV10_SH  = 19;
  // place divide: (x * recip) >> 23, exact for x below 8192
  localparam int          PLACE_SH  = 23;

  typedef enum logic [1:0] {
    PH_STARTUP = 2'd0,
    PH_RED     = 2'd1,
    PH_GREEN   = 2'd2,
    PH_YELLOW  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    REG_STARTUP = 2'd0,
    REG_RED     = 2'd1,
    REG_GREEN   = 2'd2,
    REG_YELLOW  = 2'd3
  } cfg_reg_e;

  typedef logic [DUR_W-1:0]         dur_t;
  typedef dur_t [REG_COUNT-1:0]     dur_set_t;

  typedef struct packed {
    phase_e phase;
    dur_t   remain;
  } stage_t;

  function automatic logic [7:0] lamp_code(phase_e ph);
    logic [7:0] code;
    case (ph)
      PH_STARTUP: code = LAMP_DARK;
      PH_RED:     code = LAMP_RED;
      PH_GREEN:   code = LAMP_GREEN;
      PH_YELLOW:  code = LAMP_YELLOW;
      default:    code = LAMP_DARK;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] seg_code(logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0:    code = 8'h3f;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5b;
      4'd3:    code = 8'h4f;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6d;
      4'd6:    code = 8'h7d;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7f;
      4'd9:    code = 8'h6f;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

  // reciprocal of 1000, 100, 10, 1 scaled by 2^23
  function automatic logic [23:0] place_recip(logic [1:0] pos);
    logic [23:0] r;
    case (pos)
      2'd0:    r = 24'd8389;
      2'd1:    r = 24'd83887;
      2'd2:    r = 24'd838861;
      2'd3:    r = 24'd8388608;
      default: r = 24'd8388608;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/tlc_cfg.sv =====
// tlc_cfg: phase duration register file behind the configuration write port
// depends on tlc_pkg

module tlc_cfg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i,
  output tlc_pkg::dur_set_t     durations_o
);
  import tlc_pkg::*;

  dur_set_t dur_q;

  assign cfg_ready_o = 1'b1;
  assign durations_o = dur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q[REG_STARTUP] <= STARTUP_RST;
      dur_q[REG_RED]     <= RED_RST;
      dur_q[REG_GREEN]   <= GREEN_RST;
      dur_q[REG_YELLOW]  <= YELLOW_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_STARTUP: dur_q[REG_STARTUP] <= cfg_data_i;
        REG_RED:     dur_q[REG_RED]     <= cfg_data_i;
        REG_GREEN:   dur_q[REG_GREEN]   <= cfg_data_i;
        REG_YELLOW:  dur_q[REG_YELLOW]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/tlc_phase.sv =====
// tlc_phase: phase sequencer, tick counter and digit scan position; first pipeline stage
// depends on tlc_pkg; feeds tlc_digit with the remaining ticks of each beat

module tlc_phase #(
  parameter int DIGIT_COUNT = tlc_pkg::DIGIT_COUNT_DEF,
  parameter int POS_W       = $clog2(DIGIT_COUNT)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tlc_pkg::dur_set_t     durations_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  tick_i,
  input  logic                  scan_i,
  input  logic                  ready_i,
  output logic                  valid_o,
  output tlc_pkg::stage_t       stage_o,
  output logic [POS_W-1:0]      pos_o
);
  import tlc_pkg::*;

  phase_e            phase_q, phase_d, phase_nxt;
  dur_t              elapsed_q, elapsed_d;
  logic [POS_W-1:0]  scan_pos_q, scan_pos_d;
  logic              valid_q;
  stage_t            stage_q, stage_d;
  logic [POS_W-1:0]  pos_q;
  logic              accept, ph_end, nonpos;
  logic [DUR_W:0]    cnt;
  logic [DUR_W+1:0]  diff;

  assign in_stall_o = valid_q && !ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cnt       = {1'b0, elapsed_q} + (DUR_W+1)'(tick_i);
    diff      = {2'b00, durations_i[phase_q]} - {1'b0, cnt};
    nonpos    = diff[DUR_W+1] || (diff == '0);
    ph_end    = tick_i && nonpos;
    phase_nxt = (phase_q == PH_YELLOW) ? PH_RED : phase_e'(phase_q + 2'd1);
    phase_d   = ph_end ? phase_nxt : phase_q;
    elapsed_d = ph_end ? '0 : cnt[DUR_W-1:0];
    stage_d.phase  = phase_d;
    stage_d.remain = ph_end ? durations_i[phase_nxt] : (nonpos ? '0 : diff[DUR_W-1:0]);
    scan_pos_d = (scan_pos_q == POS_W'(DIGIT_COUNT - 1)) ? '0 : scan_pos_q + POS_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_STARTUP;
      elapsed_q  <= '0;
      scan_pos_q <= '0;
      valid_q    <= 1'b0;
    end else begin
      if (accept) begin
        phase_q   <= phase_d;
        elapsed_q <= elapsed_d;
        if (scan_i) begin
          scan_pos_q <= scan_pos_d;
        end
      end
      if (!in_stall_o) begin
        valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q <= stage_d;
      pos_q   <= scan_pos_q;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;
  assign pos_o   = pos_q;

`ifndef SYNTHESIS
  a_no_return_to_startup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_STARTUP |=> phase_q != PH_STARTUP)
    else $error("sequencer returned to startup phase");

  a_phase_change_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != $past(phase_q) |-> elapsed_q == '0)
    else $error("phase changed without clearing tick count");

  a_stage_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !ready_i |=> valid_q && $stable(stage_q) && $stable(pos_q))
    else $error("stalled stage beat lost or changed");
`endif

endmodule

// ===== sv/tlc_digit.sv =====
// tlc_digit: countdown to display pipeline: tenths, place divide, digit and segment coding
// depends on tlc_pkg; takes the stage beats of tlc_phase, drives the output register

module tlc_digit #(
  parameter int DIGIT_COUNT = tlc_pkg::DIGIT_COUNT_DEF,
  parameter int POS_W       = $clog2(DIGIT_COUNT)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  tlc_pkg::stage_t         stage_i,
  input  logic [POS_W-1:0]        pos_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [7:0]              lamp_pattern_o,
  output logic [7:0]              segment_pattern_o,
  output logic [DIGIT_COUNT-1:0]  digit_select_o,
  output logic [1:0]              phase_now_o
);
  import tlc_pkg::*;

  logic v2_q, v3_q, v4_q;
  logic rdy2, rdy3, rdy4;

  // stage 2: tenths of a second
  logic [31:0]       tenths_prod;
  logic [12:0]       tenths_q;
  phase_e            ph2_q;
  logic [POS_W-1:0]  pos2_q;

  // stage 3: quotient by place value
  logic [36:0]       place_prod;
  logic [12:0]       quot_q;
  phase_e            ph3_q;
  logic [POS_W-1:0]  pos3_q;

  // stage 4: decimal digit and output register
  logic [28:0]       q10_prod;
  logic [9:0]        q10;
  logic [13:0]       q10x10;
  logic [13:0]       rem;
  logic [7:0]        seg_d;
  logic [7:0]        lamp_q, seg_q;
  logic [DIGIT_COUNT-1:0] sel_q;
  phase_e            ph4_q;

  assign rdy4    = !v4_q || !out_stall_i;
  assign rdy3    = !v3_q || rdy4;
  assign rdy2    = !v2_q || rdy3;
  assign ready_o = rdy2;

  always_comb begin
    tenths_prod = stage_i.remain * DIV10_MUL;
    place_prod  = {11'd0, tenths_q} * {13'd0, place_recip(2'(pos2_q))};
    q10_prod    = {16'd0, quot_q} * {13'd0, DIV10_MUL};
    q10         = q10_prod[DIV10_SH +: 10];
    q10x10      = {1'b0, q10, 3'b000} + {3'b000, q10, 1'b0};
    rem         = {1'b0, quot_q} - q10x10;
    seg_d       = seg_code(rem[3:0]);
    if (pos3_q == POS_W'(DP_DIGIT)) begin
      seg_d = seg_d | DP_BIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_q <= valid_i;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      tenths_q <= tenths_prod[DIV10_SH +: 13];
      ph2_q    <= stage_i.phase;
      pos2_q   <= pos_i;
    end
    if (rdy3) begin
      quot_q <= place_prod[PLACE_SH +: 13];
      ph3_q  <= ph2_q;
      pos3_q <= pos2_q;
    end
    if (rdy4) begin
      lamp_q <= lamp_code(ph3_q);
      seg_q  <= seg_d;
      sel_q  <= {{(DIGIT_COUNT-1){1'b0}}, 1'b1} << pos3_q;
      ph4_q  <= ph3_q;
    end
  end

  assign out_valid_o       = v4_q;
  assign lamp_pattern_o    = lamp_q;
  assign segment_pattern_o = seg_q;
  assign digit_select_o    = sel_q;
  assign phase_now_o       = ph4_q;

`ifndef SYNTHESIS
  a_digit_below_ten: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> rem < 14'd10)
    else $error("decimal digit out of range");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && out_stall_i |=> v4_q && $stable(seg_q) && $stable(sel_q) && $stable(lamp_q))
    else $error("stalled result changed");

  a_pipe_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !rdy3 |=> v3_q && $stable(quot_q))
    else $error("stage 3 beat overwritten");
`endif

endmodule

// ===== sv/traffic_light_countdown_sequencer.sv =====
// traffic_light_countdown_sequencer: top level, config registers, phase stage, display pipeline
// a result beat passes the phase stage register and display stages 2, 3 and 4 after its input beat
// is accepted; throughput: one input beat per cycle while in_stall_o is low; the phase stage and
// the three-stage display pipeline set the latency
// reset: asynchronous, active low; startup phase, zero tick count, leftmost digit,
// durations back to 100, 3000, 1000 and 300 ticks, pipeline empty; depends on tlc_pkg,
// tlc_cfg, tlc_phase and tlc_digit

module traffic_light_countdown_sequencer #(
  parameter int DIGIT_COUNT = tlc_pkg::DIGIT_COUNT_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [1:0]              cfg_index_i,
  input  logic [15:0]             cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    tick_strobe_i,
  input  logic                    scan_strobe_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [7:0]              lamp_pattern_o,
  output logic [7:0]              segment_pattern_o,
  output logic [DIGIT_COUNT-1:0]  digit_select_o,
  output logic [1:0]              phase_now_o
);
  import tlc_pkg::*;

  localparam int POS_W = $clog2(DIGIT_COUNT);

  dur_set_t          durations;
  stage_t            stage;
  logic [POS_W-1:0]  pos;
  logic              stage_valid, stage_ready;

  tlc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .durations_o (durations)
  );

  tlc_phase #(
    .DIGIT_COUNT (DIGIT_COUNT),
    .POS_W       (POS_W)
  ) u_phase (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .durations_i (durations),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .tick_i      (tick_strobe_i),
    .scan_i      (scan_strobe_i),
    .ready_i     (stage_ready),
    .valid_o     (stage_valid),
    .stage_o     (stage),
    .pos_o       (pos)
  );

  tlc_digit #(
    .DIGIT_COUNT (DIGIT_COUNT),
    .POS_W       (POS_W)
  ) u_digit (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (stage_valid),
    .ready_o           (stage_ready),
    .stage_i           (stage),
    .pos_i             (pos),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .lamp_pattern_o    (lamp_pattern_o),
    .segment_pattern_o (segment_pattern_o),
    .digit_select_o    (digit_select_o),
    .phase_now_o       (phase_now_o)
  );

`ifndef SYNTHESIS
  a_select_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot(digit_select_o))
    else $error("digit select not one-hot");

  a_startup_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && phase_now_o == PH_STARTUP |-> lamp_pattern_o == LAMP_DARK)
    else $error("lamps lit during startup");

  a_dp_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> segment_pattern_o[7] == digit_select_o[DP_DIGIT])
    else $error("decimal point on wrong digit");
`endif

endmodule
